// File: rtl/cdo_pkg.sv
// Package for the Gregorian date-add-days core.
// Holds the shared types, calendar constants and month-length function.
// No dependencies.
package cdo_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffW    = 17;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [YearW-1:0]  MaxYear   = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;
  localparam logic [DayW-1:0]   DecLen    = 5'd31;

  // year / 25 via reciprocal: floor(y * 20972 / 2^19) is exact for y < 2^14
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = 29;
  localparam logic [ProdW-1:0] Recip25 = 29'd20972;
  localparam int unsigned QuotW      = 10;
  localparam logic [YearW-1:0] Century = 14'd100;
  localparam logic [6:0] LastYearOfCentury = 7'd99;

  localparam logic [ErrW-1:0] ErrNone    = 2'd0;
  localparam logic [ErrW-1:0] ErrInvalid = 2'd1;
  localparam logic [ErrW-1:0] ErrRange   = 2'd2;

  typedef struct packed {
    logic load;     // capture input word
    logic div;      // year / 25
    logic modc;     // year mod 100 and century mod 4
    logic check;    // validate start date
    logic step;     // one month of the walk
    logic out_load; // move result to the output register
  } cdo_cmd_t;

  typedef struct packed {
    logic fin;      // walk lands inside current month
    logic ovf;      // walk left years 0..9999
  } cdo_stat_t;

  function automatic logic [DayW-1:0] month_len(input logic leap,
                                                input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/cdo_ctrl.sv
// Controller for the date-add-days core: sequences load, residue setup,
// validation, the month walk and the output register. Uses cdo_pkg.
module cdo_ctrl
  import cdo_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  cdo_stat_t stat_i,
  output cdo_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv   = 6'b000010,
    StMod   = 6'b000100,
    StCheck = 6'b001000,
    StWalk  = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        state_d   = StMod;
      end
      StMod: begin
        cmd_o.modc = 1'b1;
        state_d    = StCheck;
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = StWalk;
      end
      StWalk: begin
        cmd_o.step = 1'b1;
        if (stat_i.fin || stat_i.ovf) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/cdo_dp.sv
// Datapath for the date-add-days core: date registers, leap residues,
// remaining-day counter, month step logic and output register. Uses cdo_pkg.
module cdo_dp
  import cdo_pkg::*;
(
  input  logic                clk_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  cdo_cmd_t            cmd_i,
  output cdo_stat_t           stat_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic [ErrW-1:0]     out_err_o
);

  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [OffW-1:0]   rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [QuotW-1:0]  q25_q, q25_d;
  logic [6:0]        c100_q, c100_d;    // year mod 100
  logic [1:0]        cent_q, cent_d;    // (year / 100) mod 4
  logic [ErrW-1:0]   err_q, err_d;
  logic [OutDataW-1:0] out_data_q;
  logic [ErrW-1:0]     out_err_q;

  logic [OffW-1:0]   off_in;
  logic [ProdW-1:0]  prod;
  logic [YearW-1:0]  mod100;
  logic              leap;
  logic [DayW-1:0]   len_cur, len_prev;
  logic [OffW:0]     fwd_sum;
  logic              fwd_fin, bwd_fin;
  logic              wrap_up, wrap_dn;
  logic              invalid;
  logic [6:0]        c100_inc, c100_dec;
  logic [1:0]        cent_inc, cent_dec;

  assign off_in = in_data_i[39:23];
  assign prod   = ProdW'(year_q) * Recip25;
  assign mod100 = year_q - YearW'(q25_q[QuotW-1:2]) * Century;

  assign leap = ((year_q[1:0] == 2'd0) && (c100_q != 7'd0)) ||
                ((c100_q == 7'd0) && (cent_q == 2'd0));
  assign len_cur  = month_len(leap, month_q);
  assign len_prev = (month_q == MonthJan) ? DecLen : month_len(leap, month_q - 4'd1);

  assign invalid = (year_q > MaxYear) || (len_cur == 5'd0) || (day_q == 5'd0) ||
                   (day_q > len_cur);

  assign fwd_sum = (OffW+1)'(day_q) + (OffW+1)'(rem_q);
  assign fwd_fin = fwd_sum <= (OffW+1)'(len_cur);
  assign bwd_fin = rem_q < OffW'(day_q);
  assign wrap_up = (month_q == MonthDec) && (year_q == MaxYear);
  assign wrap_dn = (month_q == MonthJan) && (year_q == '0);

  assign c100_inc = (c100_q == LastYearOfCentury) ? 7'd0 : c100_q + 7'd1;
  assign cent_inc = (c100_q == LastYearOfCentury) ? cent_q + 2'd1 : cent_q;
  assign c100_dec = (c100_q == 7'd0) ? LastYearOfCentury : c100_q - 7'd1;
  assign cent_dec = (c100_q == 7'd0) ? cent_q - 2'd1 : cent_q;

  assign stat_o.fin = neg_q ? bwd_fin : fwd_fin;
  assign stat_o.ovf = neg_q ? (!bwd_fin && wrap_dn) : (!fwd_fin && wrap_up);

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    q25_d   = q25_q;
    c100_d  = c100_q;
    cent_d  = cent_q;
    err_d   = err_q;
    if (cmd_i.load) begin
      year_d  = in_data_i[13:0];
      month_d = in_data_i[17:14];
      day_d   = in_data_i[22:18];
      neg_d   = off_in[OffW-1];
      // magnitude; -65536 comes out as 65536 in 17 unsigned bits
      rem_d   = off_in[OffW-1] ? (~off_in + OffW'(1)) : off_in;
    end
    if (cmd_i.div) begin
      q25_d = prod[RecipShift +: QuotW];
    end
    if (cmd_i.modc) begin
      c100_d = mod100[6:0];
      cent_d = q25_q[3:2];
    end
    if (cmd_i.check) begin
      if (invalid) begin
        year_d  = '0;
        month_d = MonthJan;
        day_d   = 5'd1;
        c100_d  = '0;
        cent_d  = '0;
        err_d   = ErrInvalid;
      end else begin
        err_d = ErrNone;
      end
    end
    if (cmd_i.step) begin
      if (!neg_q) begin
        if (fwd_fin) begin
          day_d = fwd_sum[DayW-1:0];
        end else if (wrap_up) begin
          year_d  = MaxYear;
          month_d = MonthDec;
          day_d   = DecLen;
          err_d   = ErrRange;
        end else begin
          rem_d = rem_q - OffW'(len_cur) + OffW'(day_q) - OffW'(1);
          day_d = 5'd1;
          if (month_q == MonthDec) begin
            year_d  = year_q + 14'd1;
            month_d = MonthJan;
            c100_d  = c100_inc;
            cent_d  = cent_inc;
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end else begin
        if (bwd_fin) begin
          day_d = day_q - rem_q[DayW-1:0];
        end else if (wrap_dn) begin
          year_d  = '0;
          month_d = MonthJan;
          day_d   = 5'd1;
          err_d   = ErrRange;
        end else begin
          rem_d = rem_q - OffW'(day_q);
          day_d = len_prev;
          if (month_q == MonthJan) begin
            year_d  = year_q - 14'd1;
            month_d = MonthDec;
            c100_d  = c100_dec;
            cent_d  = cent_dec;
          end else begin
            month_d = month_q - 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    q25_q   <= q25_d;
    c100_q  <= c100_d;
    cent_q  <= cent_d;
    err_q   <= err_d;
    if (cmd_i.out_load) begin
      out_data_q <= {1'b0, day_q, month_q, year_q};
      out_err_q  <= err_q;
    end
  end

  assign out_data_o = out_data_q;
  assign out_err_o  = out_err_q;

endmodule

// File: rtl/calendar_date_day_offset_core.sv
// Top level of the Gregorian date-add-days core.
// Joins cdo_ctrl and cdo_dp; uses cdo_pkg.
//
// channel | dir | handshake              | contents
// s_axis  | in  | s_axis_tvalid/tready   | start date and signed day offset
// m_axis  | out | m_axis_tvalid/tready   | result date, error code in tuser
//
// A word goes from accept through divide, residue setup, check, the month walk and emit;
// the walk crosses up to about 2155 months for a 65536-day offset, stepping one month
// per cycle through the datapath. One word is in work at a time;
// a new word is taken while the previous result waits in the output register.
// rst_ni clears the controller and output valid; payload registers are not reset.
module calendar_date_day_offset_core
  import cdo_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day, [39:23] day_offset
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] date_error
  output logic [ErrW-1:0]     m_axis_tuser
);

  cdo_cmd_t  cmd;
  cdo_stat_t stat;

  cdo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdo_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata),
    .out_err_o  (m_axis_tuser)
  );

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:14] >= MonthJan) &&
                      (m_axis_tdata[17:14] <= MonthDec))
    else $error("result month out of range");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[22:18] != 5'd0))
    else $error("result day is zero");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined error code");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ErrRange)) |->
      ((m_axis_tdata[22:0] == {5'd1, MonthJan, 14'd0}) ||
       (m_axis_tdata[22:0] == {DecLen, MonthDec, MaxYear})))
    else $error("out-of-range result not saturated");

endmodule

// File: tb/sv/calendar_date_day_offset_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_day_offset_core: directed and random
// dates with signed day offsets, checked against a behavioral date predictor.
// Depends on cdo_pkg and the core RTL.
module calendar_date_day_offset_core_test;
  import cdo_pkg::*;

  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned RandomItems = 248;

  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [ErrW-1:0]   err;
  } cal_date_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [ErrW-1:0]     m_axis_tuser;

  cal_date_t   pending_dates[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  calendar_date_day_offset_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit is_leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint y, longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // days from 0-1-1 to the first day of year y
  function automatic longint days_before_year(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic cal_date_t shifted_date(logic [YearW-1:0] year, logic [MonthW-1:0] month,
                                             logic [DayW-1:0] day, logic [OffW-1:0] offset);
    cal_date_t res;
    longint    y, m, d, n, span;
    y = year;
    m = month;
    d = day;
    res.err = ErrNone;
    if (y > MaxYear || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
      y = 0;
      m = 1;
      d = 1;
      res.err = ErrInvalid;
    end
    n = days_before_year(y) + d - 1;
    for (longint k = 1; k < m; k++) n += month_days(y, k);
    n += longint'($signed(offset));
    span = days_before_year(longint'(MaxYear) + 1);
    if (n < 0) begin
      y = 0;
      m = 1;
      d = 1;
      res.err = ErrRange;
    end else if (n >= span) begin
      y = MaxYear;
      m = 12;
      d = 31;
      res.err = ErrRange;
    end else begin
      y = (n * 400) / 146097;
      if (y > MaxYear) y = MaxYear;
      while (y > 0 && days_before_year(y) > n) y--;
      while (y < MaxYear && days_before_year(y + 1) <= n) y++;
      n -= days_before_year(y);
      m = 1;
      while (m < 12 && n >= month_days(y, m)) begin
        n -= month_days(y, m);
        m++;
      end
      d = n + 1;
    end
    res.year  = y[YearW-1:0];
    res.month = m[MonthW-1:0];
    res.day   = d[DayW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_date(int year, int month, int day, int offset);
    logic [YearW-1:0]  y;
    logic [MonthW-1:0] m;
    logic [DayW-1:0]   d;
    logic [OffW-1:0]   o;
    y = year[YearW-1:0];
    m = month[MonthW-1:0];
    d = day[DayW-1:0];
    o = offset[OffW-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {o, d, m, y};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(shifted_date(y, m, d, o));
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    cal_date_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual tdata=%h tuser=%h",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        report_field("result_year", want.year, m_axis_tdata[13:0]);
        report_field("result_month", want.month, m_axis_tdata[17:14]);
        report_field("result_day", want.day, m_axis_tdata[22:18]);
        report_field("pad bit", 0, m_axis_tdata[23]);
        report_field("date_error", want.err, m_axis_tuser);
      end
    end
  end

  // watchdog: cycles without any word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, StallLimit);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  task automatic test_field_extremes();
    send_date(0, 1, 1, 0);
    send_date(9999, 12, 31, 0);
    send_date(0, 1, 1, 65535);
    send_date(9999, 12, 31, -65536);
    send_date(2000, 2, 29, -65535);
    // all-ones fields: invalid start and underflow together
    send_date(16383, 15, 31, -1);
  endtask

  task automatic test_invalid_start();
    send_date(2023, 0, 10, 5);
    send_date(2023, 13, 1, 5);
    send_date(2023, 4, 0, 5);
    send_date(2023, 4, 31, 1);
    send_date(1900, 2, 29, 0);
    send_date(10000, 1, 1, 10);
  endtask

  task automatic test_range_saturation();
    send_date(0, 1, 1, -1);
    send_date(9999, 12, 31, 1);
    send_date(9999, 12, 1, 30);
    send_date(0, 3, 1, -60);
  endtask

  task automatic test_leap_rules();
    send_date(2000, 2, 28, 1);
    send_date(1900, 2, 28, 1);
    send_date(2024, 2, 29, 365);
    send_date(2100, 3, 1, -1);
    send_date(1999, 12, 31, 1);
    send_date(2400, 2, 29, 0);
  endtask

  task automatic send_random_date();
    int y, m, d, o;
    if ($urandom_range(99) < 15) begin
      y = $urandom_range(16383);
      m = $urandom_range(15);
      d = $urandom_range(31);
    end else begin
      if ($urandom_range(9) < 2) y = $urandom_range(1) ? $urandom_range(3)
                                                      : $urandom_range(9999, 9996);
      else y = $urandom_range(9999);
      m = $urandom_range(12, 1);
      d = $urandom_range(month_days(y, m), 1);
    end
    // mostly short walks, some spanning the whole offset range
    case ($urandom_range(9))
      0, 1, 2, 3, 4: o = $urandom_range(120) - 60;
      5, 6, 7:       o = $urandom_range(4000) - 2000;
      default:       o = $urandom_range(131071) - 65536;
    endcase
    send_date(y, m, d, o);
  endtask

  task automatic test_backpressure();
    int unsigned saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_cycles = HoldCycles;
    // short walks, so the output register and the walk fill well inside the hold
    for (int i = 0; i < 6; i++) send_date(2020, 5, 10 + i, i - 3);
    send_idle_pct = saved;
  endtask

  task automatic test_random_dates();
    send_idle_pct = 32;
    recv_idle_pct = 46;
    repeat (RandomItems / 3) send_random_date();
    send_idle_pct = 46;
    recv_idle_pct = 32;
    repeat (RandomItems / 3) send_random_date();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RandomItems - 2 * (RandomItems / 3)) send_random_date();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 32;
    recv_idle_pct = 46;
    test_field_extremes();
    test_invalid_start();
    test_range_saturation();
    test_leap_rules();
    test_backpressure();
    test_random_dates();
    s_axis_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
